[src/nssa_pkg.sv]
// nssa_pkg: shared types and constants for the node slot stack allocator
// beat structs for the request and result channels, occupancy store request
// no dependencies
`timescale 1ns / 1ps

package nssa_pkg;

  localparam int MODE_W = 1;
  localparam int CNT_W  = 4;
  localparam int SLOT_W = 10;
  localparam int POS_W  = 11;
  localparam int LIM_W  = 11;

  localparam logic [MODE_W-1:0] MODE_ALLOC = 1'b0;
  localparam logic [MODE_W-1:0] MODE_FREE  = 1'b1;

  localparam logic [LIM_W-1:0] LIMIT_RST = 11'd1024;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [CNT_W-1:0]  count;
    logic [SLOT_W-1:0] slot;
  } in_beat_t;

  typedef struct packed {
    logic              fail;
    logic [SLOT_W-1:0] first_slot;
    logic              overlap;
    logic [POS_W-1:0]  top_count;
  } out_beat_t;

  typedef struct packed {
    logic             rd_en;
    logic [POS_W-1:0] rd_pos;
    logic             wr_en;
    logic [POS_W-1:0] wr_pos;
    logic             wr_bit;
  } occ_req_t;

endpackage

[src/nssa_occ_store.sv]
// nssa_occ_store: one-bit-per-slot occupancy memory, one read and one write port
// read data registered; entries at or above the fill mark read as free
// depends on nssa_pkg
`timescale 1ns / 1ps

module nssa_occ_store #(
  parameter int DEPTH = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  nssa_pkg::occ_req_t req,
  output logic               rd_hit
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int HW = nssa_pkg::POS_W + 1;

  logic          mem [DEPTH];
  logic          rd_bit_r;
  logic          rd_in_r;
  logic [HW-1:0] hwm_r;
  logic [HW-1:0] hwm_nxt;
  logic [HW-1:0] wr_end;

  assign wr_end = HW'(req.wr_pos) + HW'(1);

  always_comb begin
    hwm_nxt = hwm_r;
    if (req.wr_en && req.wr_bit && (wr_end > hwm_r)) begin
      hwm_nxt = wr_end;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[AW'(req.wr_pos)] <= req.wr_bit;
    end
    if (req.rd_en) begin
      rd_bit_r <= mem[AW'(req.rd_pos)];
      rd_in_r  <= (HW'(req.rd_pos) < hwm_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hwm_r <= '0;
    end else begin
      hwm_r <= hwm_nxt;
    end
  end

  assign rd_hit = rd_bit_r & rd_in_r;

endmodule

[src/node_slot_stack_allocator_unit.sv]
// node_slot_stack_allocator_unit: an allocate runs one memory read-modify-write per slot in
// S_MARK, then a drain state and a result state; a failed or empty allocation and a free that
// leaves top alone go straight to the result state; a free of the top slot walks top down
// one slot at a time (read then check) until a used slot is found or top hits zero.
// one request at a time; result register lets the next request start before it is taken.
// synchronous reset clears top and fill mark, sets limit to 1024; no clearing pass needed.
`timescale 1ns / 1ps

module node_slot_stack_allocator_unit #(
  parameter int MAX_SLOTS = 1024,
  parameter int MAX_RUN   = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  nssa_pkg::in_beat_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output nssa_pkg::out_beat_t              out_data,
  input  logic                             cfg_wr_en,
  input  logic [nssa_pkg::LIM_W-1:0]       cfg_wr_data
);

  localparam int PW      = nssa_pkg::POS_W;
  localparam int CW      = nssa_pkg::CNT_W;
  localparam int SW      = nssa_pkg::SLOT_W;
  localparam int LW      = nssa_pkg::LIM_W;
  localparam int LIM_CAP = (MAX_SLOTS < 2047) ? MAX_SLOTS : 2047;

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_MARK     = 6'b000010,
    S_DRAIN    = 6'b000100,
    S_WALK_RD  = 6'b001000,
    S_WALK_CHK = 6'b010000,
    S_RESP     = 6'b100000
  } state_t;

  state_t              state_r, state_nxt;
  logic [PW-1:0]       top_r, top_nxt;
  logic [LW-1:0]       limit_r;
  logic [CW-1:0]       run_r, run_nxt;
  logic [CW-1:0]       k_r, k_nxt;
  logic                ovl_r, ovl_nxt;
  logic                fail_r, fail_nxt;
  logic [SW-1:0]       first_r, first_nxt;
  logic                rd_pend_r;
  logic                out_valid_r, out_valid_nxt;
  nssa_pkg::out_beat_t out_r, out_nxt;

  nssa_pkg::occ_req_t  req;
  logic                rd_hit;

  logic [LW-1:0]       lim;
  logic [CW-1:0]       run_in;
  logic [PW:0]         alloc_end;
  logic                accept;

  nssa_occ_store #(
    .DEPTH (MAX_SLOTS)
  ) u_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (req),
    .rd_hit (rd_hit)
  );

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign lim       = (limit_r > LW'(LIM_CAP)) ? LW'(LIM_CAP) : limit_r;
  assign run_in    = (32'(in_data.count) > MAX_RUN) ? CW'(MAX_RUN) : in_data.count;
  assign alloc_end = (PW+1)'(top_r) + (PW+1)'(run_in);

  always_comb begin
    state_nxt     = state_r;
    top_nxt       = top_r;
    run_nxt       = run_r;
    k_nxt         = k_r;
    ovl_nxt       = ovl_r;
    fail_nxt      = fail_r;
    first_nxt     = first_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    req           = '0;

    if (rd_pend_r && rd_hit) begin
      ovl_nxt = 1'b1;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          fail_nxt  = 1'b0;
          first_nxt = '0;
          ovl_nxt   = 1'b0;
          state_nxt = S_RESP;
          if (in_data.mode == nssa_pkg::MODE_ALLOC) begin
            if (alloc_end > (PW+1)'(lim)) begin
              fail_nxt = 1'b1;
            end else if (run_in == '0) begin
              first_nxt = top_r[SW-1:0];
            end else begin
              run_nxt   = run_in;
              k_nxt     = '0;
              state_nxt = S_MARK;
            end
          end else if (32'(in_data.slot) < MAX_SLOTS) begin
            req.wr_en  = 1'b1;
            req.wr_pos = PW'(in_data.slot);
            req.wr_bit = 1'b0;
            if ((top_r != '0) && (PW'(in_data.slot) == top_r - PW'(1))) begin
              top_nxt   = PW'(in_data.slot);
              state_nxt = S_WALK_RD;
            end
          end
        end
      end
      S_MARK: begin
        req.rd_en  = 1'b1;
        req.rd_pos = top_r + PW'(k_r);
        req.wr_en  = 1'b1;
        req.wr_pos = top_r + PW'(k_r);
        req.wr_bit = 1'b1;
        k_nxt      = k_r + CW'(1);
        if (k_nxt == run_r) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        first_nxt = top_r[SW-1:0];
        top_nxt   = top_r + PW'(run_r);
        state_nxt = S_RESP;
      end
      S_WALK_RD: begin
        if (top_r == '0) begin
          state_nxt = S_RESP;
        end else begin
          req.rd_en  = 1'b1;
          req.rd_pos = top_r - PW'(1);
          state_nxt  = S_WALK_CHK;
        end
      end
      S_WALK_CHK: begin
        if (!rd_hit) begin
          top_nxt   = top_r - PW'(1);
          state_nxt = S_WALK_RD;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt      = 1'b1;
          out_nxt.fail       = fail_r;
          out_nxt.first_slot = first_r;
          out_nxt.overlap    = ovl_r;
          out_nxt.top_count  = top_r;
          state_nxt          = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      top_r       <= '0;
      limit_r     <= nssa_pkg::LIMIT_RST;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      top_r       <= top_nxt;
      rd_pend_r   <= (state_r == S_MARK);
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    run_r   <= run_nxt;
    k_r     <= k_nxt;
    ovl_r   <= ovl_nxt;
    fail_r  <= fail_nxt;
    first_r <= first_nxt;
    out_r   <= out_nxt;
  end

  a_top_capped: assert property (@(posedge clk) disable iff (!rst_n)
    top_r <= LW'(LIM_CAP))
    else $error("top above usable slot count");

  a_walk_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK_CHK) && !rd_hit |=> top_r == $past(top_r) - PW'(1))
    else $error("top walk did not drop by one");

  a_mark_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MARK) |-> (k_r < run_r))
    else $error("mark index past run length");

  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.fail |-> !out_r.overlap && (out_r.first_slot == '0))
    else $error("failed allocation reports a slot");

endmodule

[test/node_slot_stack_allocator_unit_test.sv]
// node_slot_stack_allocator_unit_test: self-checking bench for the slot stack allocator
// directed table of requests and limit writes, then random phases over several limits
// depends on nssa_pkg and node_slot_stack_allocator_unit
`timescale 1ns / 1ps

module node_slot_stack_allocator_unit_test;

  localparam int MAX_SLOTS   = 1024;
  localparam int MAX_RUN     = 8;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASES      = 8;
  localparam int PHASE_BEATS = 175;

  typedef enum {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t                  kind;
    logic [nssa_pkg::LIM_W-1:0] limit;
    nssa_pkg::in_beat_t         beat;
    bit                         typed;
    nssa_pkg::out_beat_t        grant;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  nssa_pkg::in_beat_t in_data;
  logic out_valid;
  logic out_ready = 1'b0;
  nssa_pkg::out_beat_t out_data;
  logic cfg_wr_en;
  logic [nssa_pkg::LIM_W-1:0] cfg_wr_data;

  // allocator shadow
  bit slot_used [MAX_SLOTS];
  int stack_top;
  int limit_reg;

  nssa_pkg::out_beat_t pending_grants[$];
  plan_row_t plan[$];
  nssa_pkg::out_beat_t head_grant;
  int mismatches = 0;
  int unsigned cycle_count = 0;
  logic calm;
  int hold_asks;
  int hold_served = 0;
  int hold_left = 0;

  int phase_limit [PHASES] = '{64, 1, 0, 2047, 1024, 9, 1023, 1024};
  int phase_pct [PHASES] = '{60, 50, 50, 85, 85, 50, 60, 50};

  node_slot_stack_allocator_unit #(
    .MAX_SLOTS(MAX_SLOTS),
    .MAX_RUN(MAX_RUN)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic nssa_pkg::out_beat_t grant_for(nssa_pkg::in_beat_t b);
    nssa_pkg::out_beat_t r;
    int run;
    int lim;
    r = '0;
    if (b.mode == nssa_pkg::MODE_ALLOC) begin
      lim = (limit_reg > MAX_SLOTS) ? MAX_SLOTS : limit_reg;
      run = (int'(b.count) > MAX_RUN) ? MAX_RUN : int'(b.count);
      if (stack_top + run > lim) begin
        r.fail = 1'b1;
      end else begin
        r.first_slot = nssa_pkg::SLOT_W'(stack_top);
        for (int k = 0; k < run; k++) begin
          if (stack_top + k < MAX_SLOTS) begin
            if (slot_used[stack_top + k]) r.overlap = 1'b1;
            slot_used[stack_top + k] = 1'b1;
          end
        end
        stack_top += run;
      end
    end else begin
      slot_used[b.slot] = 1'b0;
      if (stack_top > 0 && int'(b.slot) == stack_top - 1) begin
        while (stack_top > 0 && !slot_used[stack_top - 1]) stack_top--;
      end
    end
    r.top_count = nssa_pkg::POS_W'(stack_top);
    return r;
  endfunction

  function automatic nssa_pkg::in_beat_t next_request(int alloc_pct);
    nssa_pkg::in_beat_t b;
    int lim;
    int pct;
    int aim;
    int sel;
    lim = (limit_reg > MAX_SLOTS) ? MAX_SLOTS : limit_reg;
    pct = alloc_pct;
    aim = 50;
    // drain toward the limit when it sits below top
    if (stack_top > lim) begin
      pct = 20;
      aim = 90;
    end
    b.count = nssa_pkg::CNT_W'($urandom_range(15));
    b.slot = nssa_pkg::SLOT_W'($urandom_range(MAX_SLOTS - 1));
    sel = $urandom_range(99);
    if ($urandom_range(99) < pct) begin
      b.mode = nssa_pkg::MODE_ALLOC;
      if (sel < 80) b.count = nssa_pkg::CNT_W'($urandom_range(MAX_RUN, 1));
      else if (sel < 90) b.count = '0;
      else b.count = nssa_pkg::CNT_W'($urandom_range(15, MAX_RUN + 1));
    end else begin
      b.mode = nssa_pkg::MODE_FREE;
      if (stack_top > 0 && sel < aim) b.slot = nssa_pkg::SLOT_W'(stack_top - 1);
      else if (stack_top > 0 && sel < aim + 30)
        b.slot = nssa_pkg::SLOT_W'($urandom_range(stack_top - 1));
    end
    return b;
  endfunction

  function automatic void add_req(logic [nssa_pkg::MODE_W-1:0] m, int cnt, int s);
    plan_row_t r;
    r.kind = ROW_REQ;
    r.limit = '0;
    r.beat.mode = m;
    r.beat.count = nssa_pkg::CNT_W'(cnt);
    r.beat.slot = nssa_pkg::SLOT_W'(s);
    r.typed = 1'b0;
    r.grant = '0;
    plan.push_back(r);
  endfunction

  function automatic void add_typed(logic [nssa_pkg::MODE_W-1:0] m, int cnt, int s, bit f,
                                    int first, int topv);
    plan_row_t r;
    r.kind = ROW_REQ;
    r.limit = '0;
    r.beat.mode = m;
    r.beat.count = nssa_pkg::CNT_W'(cnt);
    r.beat.slot = nssa_pkg::SLOT_W'(s);
    r.typed = 1'b1;
    r.grant.fail = f;
    r.grant.first_slot = nssa_pkg::SLOT_W'(first);
    r.grant.overlap = 1'b0;
    r.grant.top_count = nssa_pkg::POS_W'(topv);
    plan.push_back(r);
  endfunction

  function automatic void add_cfg(int v);
    plan_row_t r;
    r.kind = ROW_CFG;
    r.limit = nssa_pkg::LIM_W'(v);
    r.beat = '0;
    r.typed = 1'b0;
    r.grant = '0;
    plan.push_back(r);
  endfunction

  task automatic settle();
    if (in_valid) in_valid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_limit(int v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= nssa_pkg::LIM_W'(v);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    limit_reg = v & ((1 << nssa_pkg::LIM_W) - 1);
  endtask

  task automatic send_request(nssa_pkg::in_beat_t b, bit typed,
                              nssa_pkg::out_beat_t typed_grant);
    nssa_pkg::out_beat_t g;
    in_data <= b;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    g = grant_for(b);
    pending_grants.push_back(typed ? typed_grant : g);
    if (!calm && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
  endtask

  task automatic flag_mismatch(string what, nssa_pkg::out_beat_t want,
                               nssa_pkg::out_beat_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: want fail=%0d first=%0d ovl=%0d top=%0d, %s",
               $time, what, want.fail, want.first_slot, want.overlap, want.top_count,
               $sformatf("got fail=%0d first=%0d ovl=%0d top=%0d",
                         got.fail, got.first_slot, got.overlap, got.top_count));
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_grants.size() == 0) begin
        flag_mismatch("beat with nothing pending", '0, out_data);
      end else begin
        head_grant = pending_grants.pop_front();
        if (out_data.fail !== head_grant.fail || out_data.first_slot !== head_grant.first_slot ||
            out_data.overlap !== head_grant.overlap ||
            out_data.top_count !== head_grant.top_count)
          flag_mismatch("grant mismatch", head_grant, out_data);
      end
    end
  end

  // receiver with random stalls and a long hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_asks != hold_served) begin
      hold_served <= hold_asks;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 11);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    plan_row_t row;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    rst_n <= 1'b0;
    calm <= 1'b0;
    hold_asks <= 0;
    foreach (slot_used[i]) slot_used[i] = 1'b0;
    stack_top = 0;
    limit_reg = nssa_pkg::LIMIT_RST;

    add_typed(nssa_pkg::MODE_FREE, 0, 0, 1'b0, 0, 0);
    add_typed(nssa_pkg::MODE_ALLOC, 0, 0, 1'b0, 0, 0);
    add_typed(nssa_pkg::MODE_ALLOC, 1, 0, 1'b0, 0, 1);
    add_typed(nssa_pkg::MODE_ALLOC, 8, 0, 1'b0, 1, 9);
    add_typed(nssa_pkg::MODE_ALLOC, 15, 0, 1'b0, 9, 17);
    add_req(nssa_pkg::MODE_ALLOC, 9, 1023);
    add_req(nssa_pkg::MODE_FREE, 0, 10);
    add_req(nssa_pkg::MODE_FREE, 15, 24);
    add_req(nssa_pkg::MODE_FREE, 0, 1023);
    add_req(nssa_pkg::MODE_FREE, 0, 23);
    add_cfg(20);
    add_typed(nssa_pkg::MODE_ALLOC, 1, 0, 1'b1, 0, 23);
    add_typed(nssa_pkg::MODE_ALLOC, 0, 0, 1'b1, 0, 23);
    add_cfg(0);
    add_req(nssa_pkg::MODE_FREE, 0, 22);
    add_typed(nssa_pkg::MODE_ALLOC, 1, 0, 1'b1, 0, 22);
    add_cfg(2047);
    add_req(nssa_pkg::MODE_ALLOC, 8, 0);
    add_req(nssa_pkg::MODE_ALLOC, 0, 0);
    add_cfg(30);
    add_typed(nssa_pkg::MODE_ALLOC, 1, 0, 1'b1, 0, 30);
    add_req(nssa_pkg::MODE_ALLOC, 0, 0);
    add_req(nssa_pkg::MODE_FREE, 0, 29);
    add_req(nssa_pkg::MODE_ALLOC, 1, 0);
    add_cfg(1024);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      row = plan[i];
      if (row.kind == ROW_CFG) begin
        settle();
        write_limit(row.limit);
      end else begin
        send_request(row.beat, row.typed, row.grant);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      write_limit(phase_limit[ph]);
      calm <= (ph == 4);
      for (int n = 0; n < PHASE_BEATS; n++) begin
        // back-pressure burst while requests keep coming
        if (ph == 3 && n == 50) hold_asks <= hold_asks + 1;
        send_request(next_request(phase_pct[ph]), 1'b0, '0);
      end
    end

    if (in_valid) in_valid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
